>>> sv/tgr_pkg.sv
// Shared types, screen constants and the 5x7 font table of the text glyph rasterizer.
// No dependencies; every other file of the block refers to it by scoped names.

package tgr_pkg;

    // Screen size in pixels.
    localparam int SCREEN_WIDTH  = 800;
    localparam int SCREEN_HEIGHT = 600;

    // Glyph geometry and printable range.
    localparam logic [7:0]  GLYPH_FIRST  = 8'd32;
    localparam logic [7:0]  GLYPH_LAST   = 8'd126;
    localparam logic [2:0]  GLYPH_COLS   = 3'd5;
    localparam logic [2:0]  GLYPH_ROWS   = 3'd7;
    localparam logic [2:0]  LAST_COL     = GLYPH_COLS - 3'd1;
    localparam logic [2:0]  LAST_ROW     = GLYPH_ROWS - 3'd1;
    localparam logic [11:0] CHAR_ADVANCE = 12'd6;
    localparam logic [12:0] GLYPH_SPAN   = 13'd5;

    // Configuration register indexes and reset values.
    localparam logic REG_FOREGROUND = 1'b0;
    localparam logic REG_BACKGROUND = 1'b1;
    localparam logic [31:0] FOREGROUND_RESET = 32'hFFFF_FFFF;
    localparam logic [31:0] BACKGROUND_RESET = 32'hFF22_2222;

    // One glyph job: the origin and 5 columns of 7 row bits, column c at [7c+6:7c].
    typedef struct packed {
        logic [9:0]  x;
        logic [9:0]  y;
        logic [34:0] glyph;
    } cmd_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // Raw font bytes, column 0 in the top byte.
    function automatic logic [39:0] font_bytes(input logic [6:0] idx);
        logic [39:0] b;
        case (idx)
            7'd0:  b = 40'h0000000000;
            7'd1:  b = 40'h7f00000000;
            7'd2:  b = 40'h0300030000;
            7'd3:  b = 40'h7f147f147f;
            7'd4:  b = 40'h2a7f2a3e2a;
            7'd5:  b = 40'h6313086463;
            7'd6:  b = 40'h3649562050;
            7'd7:  b = 40'h0300000000;
            7'd8:  b = 40'h3e41000000;
            7'd9:  b = 40'h413e000000;
            7'd10: b = 40'h083e1c3e08;
            7'd11: b = 40'h08083e0808;
            7'd12: b = 40'h0050300000;
            7'd13: b = 40'h0808080808;
            7'd14: b = 40'h0060600000;
            7'd15: b = 40'h6018060100;
            7'd16: b = 40'h3e5149453e;
            7'd17: b = 40'h407f400000;
            7'd18: b = 40'h7249494946;
            7'd19: b = 40'h2141494d33;
            7'd20: b = 40'h1814127f10;
            7'd21: b = 40'h2f49494931;
            7'd22: b = 40'h3c4a494930;
            7'd23: b = 40'h0171090503;
            7'd24: b = 40'h3649494936;
            7'd25: b = 40'h064949291e;
            7'd26: b = 40'h0036360000;
            7'd27: b = 40'h0056360000;
            7'd28: b = 40'h0814224100;
            7'd29: b = 40'h1414141414;
            7'd30: b = 40'h0041221408;
            7'd31: b = 40'h0201510906;
            7'd32: b = 40'h324979413e;
            7'd33: b = 40'h7e1111117e;
            7'd34: b = 40'h7f49494936;
            7'd35: b = 40'h3e41414122;
            7'd36: b = 40'h7f4141221c;
            7'd37: b = 40'h7f49494941;
            7'd38: b = 40'h7f09090901;
            7'd39: b = 40'h3e4149497a;
            7'd40: b = 40'h7f0808087f;
            7'd41: b = 40'h00417f4100;
            7'd42: b = 40'h2040413f01;
            7'd43: b = 40'h7f08142241;
            7'd44: b = 40'h7f40404040;
            7'd45: b = 40'h7f020c027f;
            7'd46: b = 40'h7f0408107f;
            7'd47: b = 40'h3e4141413e;
            7'd48: b = 40'h7f09090906;
            7'd49: b = 40'h3e4151215e;
            7'd50: b = 40'h7f09192946;
            7'd51: b = 40'h2649494932;
            7'd52: b = 40'h01017f0101;
            7'd53: b = 40'h3f4040403f;
            7'd54: b = 40'h1f2040201f;
            7'd55: b = 40'h3f4038403f;
            7'd56: b = 40'h6314081463;
            7'd57: b = 40'h0708700807;
            7'd58: b = 40'h6151494543;
            7'd59: b = 40'h007f410000;
            7'd60: b = 40'h0106186000;
            7'd61: b = 40'h00417f0000;
            7'd62: b = 40'h0402010204;
            7'd63: b = 40'h4040404040;
            7'd64: b = 40'h0001020400;
            7'd65: b = 40'h2054545478;
            7'd66: b = 40'h7f48444438;
            7'd67: b = 40'h3844444420;
            7'd68: b = 40'h384444487f;
            7'd69: b = 40'h3854545418;
            7'd70: b = 40'h087e090102;
            7'd71: b = 40'h18a4a4a47c;
            7'd72: b = 40'h7f08040478;
            7'd73: b = 40'h00447d4000;
            7'd74: b = 40'h4080847d00;
            7'd75: b = 40'h7f10284400;
            7'd76: b = 40'h00417f4000;
            7'd77: b = 40'h7c0418047c;
            7'd78: b = 40'h7c08040478;
            7'd79: b = 40'h3844444438;
            7'd80: b = 40'hfc24242418;
            7'd81: b = 40'h18242424fc;
            7'd82: b = 40'h7c08040408;
            7'd83: b = 40'h4854545424;
            7'd84: b = 40'h043f444020;
            7'd85: b = 40'h3c4040207c;
            7'd86: b = 40'h1c2040201c;
            7'd87: b = 40'h3c4030403c;
            7'd88: b = 40'h4428102844;
            7'd89: b = 40'h1ca0a0a07c;
            7'd90: b = 40'h4464544c44;
            7'd91: b = 40'h0008364100;
            7'd92: b = 40'h00007f0000;
            7'd93: b = 40'h0041360800;
            7'd94: b = 40'h0804081008;
            default: b = 40'h0000000000;
        endcase
        return b;
    endfunction

    // Glyph bitmap of a printable code, bit 7 of each font byte dropped.
    function automatic logic [34:0] glyph_columns(input logic [7:0] code);
        logic [39:0] b;
        logic [34:0] g;
        b = font_bytes(7'(code - GLYPH_FIRST));
        g = '0;
        for (int c = 0; c < 5; c++) begin
            g[c*7 +: 7] = b[32 - 8*c +: 7];
        end
        return g;
    endfunction

endpackage

>>> sv/tgr_front.sv
// Front end of the text glyph rasterizer: accepts character words, keeps the cursor,
// and queues a glyph job for each character that draws. Depends on tgr_pkg.

module tgr_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_start_string,
    input  logic [10:0]          s_start_x,
    input  logic [9:0]           s_start_y,
    input  logic [7:0]           s_char_code,
    input  tgr_pkg::queue_stat_t q_stat,
    output logic                 push,
    output tgr_pkg::cmd_t        push_cmd
);

    logic [11:0] cursor_reg, cursor_next;
    logic [9:0]  row_reg, row_next;
    logic [11:0] cur_col;
    logic [9:0]  cur_row;
    logic        accept;
    logic        on_screen;
    logic        printable;
    logic        row_visible;

    // A word is taken whenever the queue has room for its job.
    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    // Cursor as seen by this character, after an optional string start.
    assign cur_col = s_start_string ? {1'b0, s_start_x} : cursor_reg;
    assign cur_row = s_start_string ? s_start_y : row_reg;

    // Classification of the character.
    assign on_screen   = (13'(cur_col) + tgr_pkg::GLYPH_SPAN) < 13'(tgr_pkg::SCREEN_WIDTH);
    assign printable   = s_char_code inside {[tgr_pkg::GLYPH_FIRST:tgr_pkg::GLYPH_LAST]};
    assign row_visible = 11'(cur_row) < 11'(tgr_pkg::SCREEN_HEIGHT);

    // Only characters that leave at least one pixel become jobs.
    assign push           = accept && on_screen && printable && row_visible;
    assign push_cmd.x     = cur_col[9:0];
    assign push_cmd.y     = cur_row;
    assign push_cmd.glyph = tgr_pkg::glyph_columns(s_char_code);

    // The cursor stops once the string runs off the right edge.
    always_comb begin
        cursor_next = cursor_reg;
        row_next    = row_reg;
        if (accept) begin
            row_next    = cur_row;
            cursor_next = on_screen ? (cur_col + tgr_pkg::CHAR_ADVANCE) : cur_col;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= '0;
            row_reg    <= '0;
        end else begin
            cursor_reg <= cursor_next;
            row_reg    <= row_next;
        end
    end

endmodule

>>> sv/tgr_queue.sv
// Two-entry job queue between the front and back ends of the text glyph rasterizer.
// Depends on tgr_pkg for the job type and status struct.

module tgr_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  tgr_pkg::cmd_t        push_cmd,
    input  logic                 pop,
    output tgr_pkg::cmd_t        head_cmd,
    output tgr_pkg::queue_stat_t stat
);

    tgr_pkg::cmd_t mem [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_cmd   = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> sv/tgr_back.sv
// Back end of the text glyph rasterizer: holds the colors and walks one glyph job
// pixel by pixel into the output register. Depends on tgr_pkg.

module tgr_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_wr_data,
    input  tgr_pkg::queue_stat_t q_stat,
    input  tgr_pkg::cmd_t        head_cmd,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [9:0]           m_pixel_x,
    output logic [9:0]           m_pixel_y,
    output logic [31:0]          m_pixel_color,
    output logic                 m_last_pixel
);

    logic [31:0] fg_reg, bg_reg;
    logic        busy_reg;
    logic [9:0]  x_reg, y_reg;
    logic [34:0] glyph_reg;
    logic [2:0]  col_reg, row_reg;
    logic        m_valid_reg;
    logic [9:0]  px_reg, py_reg;
    logic [31:0] color_reg;
    logic        last_reg;

    logic        step;
    logic        load;
    logic [9:0]  y_cur;
    logic [5:0]  bit_idx;
    logic        row_last;
    logic        pix_last;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg <= tgr_pkg::FOREGROUND_RESET;
            bg_reg <= tgr_pkg::BACKGROUND_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == tgr_pkg::REG_FOREGROUND) begin
                fg_reg <= cfg_wr_data;
            end else begin
                bg_reg <= cfg_wr_data;
            end
        end
    end

    // A pixel is produced when the output register is free or being drained.
    assign step = busy_reg && (!m_valid_reg || m_ready);
    assign load = !busy_reg && !q_stat.empty;
    assign pop  = load;

    // Current pixel: rows below the screen end the glyph early.
    assign y_cur    = y_reg + 10'(row_reg);
    assign bit_idx  = 6'(col_reg) * 6'd7 + 6'(row_reg);
    assign row_last = (row_reg == tgr_pkg::LAST_ROW)
                   || (11'(y_cur) + 11'd1 >= 11'(tgr_pkg::SCREEN_HEIGHT));
    assign pix_last = (col_reg == tgr_pkg::LAST_COL) && row_last;

    // Job walker, columns inner and rows outer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            col_reg  <= '0;
            row_reg  <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            col_reg  <= '0;
            row_reg  <= '0;
        end else if (step) begin
            if (pix_last) begin
                busy_reg <= 1'b0;
            end else if (col_reg == tgr_pkg::LAST_COL) begin
                col_reg <= '0;
                row_reg <= row_reg + 3'd1;
            end else begin
                col_reg <= col_reg + 3'd1;
            end
        end
    end

    // Job payload.
    always_ff @(posedge aclk) begin
        if (load) begin
            x_reg     <= head_cmd.x;
            y_reg     <= head_cmd.y;
            glyph_reg <= head_cmd.glyph;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            px_reg    <= x_reg + 10'(col_reg);
            py_reg    <= y_cur;
            color_reg <= glyph_reg[bit_idx] ? fg_reg : bg_reg;
            last_reg  <= pix_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = px_reg;
    assign m_pixel_y     = py_reg;
    assign m_pixel_color = color_reg;
    assign m_last_pixel  = last_reg;

`ifndef ASSERT_OFF
    // The walker never leaves the 5x7 cell.
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (col_reg <= tgr_pkg::LAST_COL) && (row_reg <= tgr_pkg::LAST_ROW))
        else $error("glyph walker outside 5x7 cell");

    // The final pixel of a job frees the walker.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && pix_last) |=> !busy_reg)
        else $error("walker still busy after final pixel");

    // Every emitted pixel lies on the screen vertically.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step |-> (11'(y_cur) < 11'(tgr_pkg::SCREEN_HEIGHT)))
        else $error("clipped row emitted");

    // A new job is taken only while the walker is idle, and its load starts at the first pixel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> busy_reg && (col_reg == 3'd0) && (row_reg == 3'd0))
        else $error("job load did not start at the first pixel");
`endif

endmodule

>>> sv/text_glyph_rasterizer.sv
// Top level of the text glyph rasterizer: front end, job queue and pixel back end.
// Depends on tgr_pkg, tgr_front, tgr_queue and tgr_back.
//
// Usage: each word on the s_ channel is one character. With s_start_string high the
// cursor first loads from s_start_x / s_start_y. A printable code (32..126) yields up
// to 35 pixel words on the m_ channel, rows outer and columns inner, with the
// foreground color on set glyph bits and the background color elsewhere; rows at or
// below the screen bottom are clipped. m_last_pixel marks a character's final word.
// Other codes only advance the cursor by 6; once cursor + 5 reaches the screen width
// the rest of the string is dropped until the next start.
// Throughput: one pixel word per cycle while a glyph is drawn and the output does not
// stall; the next job loads only after a glyph's final pixel. A word passes through
// the queue, the walker's job registers and the output register before its first
// pixel is valid. A two-job queue lets the front take characters while the walker is
// busy; s_ready drops only when the queue is full. When m_ready is low, the output
// register holds its word and the walker waits. Reset (aresetn low, synchronous)
// clears the cursor, the queue and the output valid, and restores the colors to
// 0xFFFFFFFF and 0xFF222222. The cfg_ port writes register 0 (foreground) or 1
// (background) while the block is idle; the user must keep to this, the block does not enforce it.

module text_glyph_rasterizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_start_string,
    input  logic [10:0] s_start_x,
    input  logic [9:0]  s_start_y,
    input  logic [7:0]  s_char_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_pixel_x,
    output logic [9:0]  m_pixel_y,
    output logic [31:0] m_pixel_color,
    output logic        m_last_pixel
);

    tgr_pkg::queue_stat_t q_stat;
    tgr_pkg::cmd_t        push_cmd;
    tgr_pkg::cmd_t        head_cmd;
    logic                 push;
    logic                 pop;

    // Character intake and cursor.
    tgr_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_start_string (s_start_string),
        .s_start_x      (s_start_x),
        .s_start_y      (s_start_y),
        .s_char_code    (s_char_code),
        .q_stat         (q_stat),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    // Glyph job queue.
    tgr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    // Pixel walker and output register.
    tgr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .q_stat        (q_stat),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_color (m_pixel_color),
        .m_last_pixel  (m_last_pixel)
    );

endmodule

>>> sim/tb.sv
// Self-checking testbench for text_glyph_rasterizer: drives characters and color writes,
// predicts every pixel word with a local 5x7 font model and checks the m_ channel.
// Depends on tgr_pkg and text_glyph_rasterizer.
`timescale 1ns / 100ps

module tb;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASE_ITEMS  = 22;

    // Font bitmaps for codes 32..126, one 40-bit group per glyph, first glyph on top.
    // Within a group column 0 is the top byte and bit r is glyph row r.
    localparam logic [3799:0] FONT_ROM = {
        40'h0000000000, 40'h7f00000000, 40'h0300030000, 40'h7f147f147f, 40'h2a7f2a3e2a,
        40'h6313086463, 40'h3649562050, 40'h0300000000, 40'h3e41000000, 40'h413e000000,
        40'h083e1c3e08, 40'h08083e0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h6018060100, 40'h3e5149453e, 40'h407f400000, 40'h7249494946, 40'h2141494d33,
        40'h1814127f10, 40'h2f49494931, 40'h3c4a494930, 40'h0171090503, 40'h3649494936,
        40'h064949291e, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h324979413e, 40'h7e1111117e, 40'h7f49494936,
        40'h3e41414122, 40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
        40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
        40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906, 40'h3e4151215e,
        40'h7f09192946, 40'h2649494932, 40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f,
        40'h3f4038403f, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f410000,
        40'h0106186000, 40'h00417f0000, 40'h0402010204, 40'h4040404040, 40'h0001020400,
        40'h2054545478, 40'h7f48444438, 40'h3844444420, 40'h384444487f, 40'h3854545418,
        40'h087e090102, 40'h18a4a4a47c, 40'h7f08040478, 40'h00447d4000, 40'h4080847d00,
        40'h7f10284400, 40'h00417f4000, 40'h7c0418047c, 40'h7c08040478, 40'h3844444438,
        40'hfc24242418, 40'h18242424fc, 40'h7c08040408, 40'h4854545424, 40'h043f444020,
        40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c, 40'h4428102844, 40'h1ca0a0a07c,
        40'h4464544c44, 40'h0008364100, 40'h00007f0000, 40'h0041360800, 40'h0804081008
    };

    typedef struct packed {
        logic [9:0]  x;
        logic [9:0]  y;
        logic [31:0] color;
        logic        last;
    } pixel_t;

    // Keeps the expected pixel words in order and compares the block's output with them.
    class glyph_scoreboard;
        logic [31:0] fg_color;
        logic [31:0] bg_color;
        logic [11:0] cursor;
        logic [9:0]  row;
        pixel_t      pending_pixels[$];
        int          errors;
        int          chars_accepted;
        int          pixels_checked;

        function new();
            fg_color       = tgr_pkg::FOREGROUND_RESET;
            bg_color       = tgr_pkg::BACKGROUND_RESET;
            cursor         = '0;
            row            = '0;
            errors         = 0;
            chars_accepted = 0;
            pixels_checked = 0;
        endfunction

        function void set_color(logic idx, logic [31:0] value);
            if (idx == tgr_pkg::REG_FOREGROUND) begin
                fg_color = value;
            end else begin
                bg_color = value;
            end
        endfunction

        // Works out the pixel words that one accepted character produces.
        function void rasterize_char(logic start, logic [10:0] sx, logic [9:0] sy,
                                     logic [7:0] code);
            int         glyph;
            int         py;
            int         px;
            logic [7:0] bits;
            pixel_t     pix;
            pixel_t     held;
            bit         have_held;
            chars_accepted++;
            have_held = 1'b0;
            if (start) begin
                cursor = {1'b0, sx};
                row    = sy;
            end
            // Past the right edge the cursor freezes and nothing is drawn.
            if (int'(cursor) + 5 >= tgr_pkg::SCREEN_WIDTH) begin
                return;
            end
            if (code >= tgr_pkg::GLYPH_FIRST && code <= tgr_pkg::GLYPH_LAST) begin
                glyph = int'(code) - int'(tgr_pkg::GLYPH_FIRST);
                for (int r = 0; r < int'(tgr_pkg::GLYPH_ROWS); r++) begin
                    py = int'(row) + r;
                    // Rows at or below the screen bottom are clipped.
                    if (py < tgr_pkg::SCREEN_HEIGHT) begin
                        for (int c = 0; c < int'(tgr_pkg::GLYPH_COLS); c++) begin
                            bits = FONT_ROM[(94 - glyph) * 40 + (4 - c) * 8 +: 8];
                            px = int'(cursor) + c;
                            pix.x = px[9:0];
                            pix.y = py[9:0];
                            // Only bits 0..6 are ever looked at, so font bit 7 never shows.
                            pix.color = bits[r] ? fg_color : bg_color;
                            pix.last  = 1'b0;
                            if (have_held) begin
                                pending_pixels.push_back(held);
                            end
                            held      = pix;
                            have_held = 1'b1;
                        end
                    end
                end
                // The final word of a character carries the last mark.
                if (have_held) begin
                    held.last = 1'b1;
                    pending_pixels.push_back(held);
                end
            end
            cursor = cursor + tgr_pkg::CHAR_ADVANCE;
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            pixels_checked++;
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel word: x=%0d y=%0d color=%h last=%0d",
                       got.x, got.y, got.color, got.last);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            if (got.x !== want.x) begin
                $error("pixel_x: expected %0d, actual %0d", want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $error("pixel_y: expected %0d, actual %0d", want.y, got.y);
                errors++;
            end
            if (got.color !== want.color) begin
                $error("pixel_color: expected %h, actual %h", want.color, got.color);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last_pixel: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [31:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_start_string;
    logic [10:0] s_start_x;
    logic [9:0]  s_start_y;
    logic [7:0]  s_char_code;
    logic        m_valid;
    logic        m_ready;
    logic [9:0]  m_pixel_x;
    logic [9:0]  m_pixel_y;
    logic [31:0] m_pixel_color;
    logic        m_last_pixel;

    glyph_scoreboard sb;
    pixel_t          seen;
    bit              no_idle;
    int              stall_cycles;
    int              color_settings;

    text_glyph_rasterizer uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_start_string (s_start_string),
        .s_start_x      (s_start_x),
        .s_start_y      (s_start_y),
        .s_char_code    (s_char_code),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_pixel_color  (m_pixel_color),
        .m_last_pixel   (m_last_pixel)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Gap length in cycles: mostly none, sometimes short, now and then long.
    function automatic int pick_gap();
        int roll;
        if (no_idle) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Mostly printable characters, with some bytes from the whole range.
    function automatic logic [7:0] pick_code();
        logic [7:0] code;
        if ($urandom_range(0, 99) < 85) begin
            code = 8'($urandom_range(32, 126));
        end else begin
            code = 8'($urandom_range(0, 255));
        end
        return code;
    endfunction

    // Offers one character word and returns once it has been accepted.
    task automatic send_char(input logic start, input logic [10:0] sx, input logic [9:0] sy,
                             input logic [7:0] code);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_start_string <= start;
        s_start_x      <= sx;
        s_start_y      <= sy;
        s_char_code    <= code;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.rasterize_char(start, sx, sy, code);
    endtask

    // Writes both color registers back to back.
    task automatic load_colors(input logic [31:0] fg, input logic [31:0] bg);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= tgr_pkg::REG_FOREGROUND;
        cfg_wr_data <= fg;
        @(posedge aclk);
        sb.set_color(tgr_pkg::REG_FOREGROUND, fg);
        cfg_index   <= tgr_pkg::REG_BACKGROUND;
        cfg_wr_data <= bg;
        @(posedge aclk);
        sb.set_color(tgr_pkg::REG_BACKGROUND, bg);
        cfg_wr_en <= 1'b0;
        color_settings++;
    endtask

    // Waits for every expected word, then lets glyphs that draw nothing clear the pipeline.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One string: usually a start word and mostly printable text, sometimes a bare continuation.
    task automatic send_random_string(output int count);
        int          roll;
        bit          lead;
        logic [10:0] sx;
        logic [9:0]  sy;
        logic [10:0] junk_x;
        logic [9:0]  junk_y;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            sx = 11'($urandom_range(0, 700));
        end else if (roll < 90) begin
            sx = 11'($urandom_range(700, 800));
        end else begin
            sx = 11'($urandom_range(0, 2047));
        end
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
            sy = 10'($urandom_range(0, 590));
        end else if (roll < 90) begin
            sy = 10'($urandom_range(590, 605));
        end else begin
            sy = 10'($urandom_range(0, 1023));
        end
        lead  = ($urandom_range(0, 9) != 0);
        count = $urandom_range(1, 12);
        for (int i = 0; i < count; i++) begin
            junk_x = 11'($urandom);
            junk_y = 10'($urandom);
            if (i == 0 && lead) begin
                send_char(1'b1, sx, sy, pick_code());
            end else begin
                send_char(1'b0, junk_x, junk_y, pick_code());
            end
        end
    endtask

    task automatic run_random_phase();
        int sent;
        int n;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            send_random_string(n);
            sent += n;
        end
    endtask

    // Result side: random stalls on m_ready.
    initial begin
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // Every accepted pixel word goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen.x     = m_pixel_x;
            seen.y     = m_pixel_y;
            seen.color = m_pixel_color;
            seen.last  = m_last_pixel;
            sb.check_pixel(seen);
        end
    end

    // Counts cycles without any handshake.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("Watchdog expired after %0d cycles without progress", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        sb             = new();
        no_idle        = 1'b0;
        color_settings = 0;
        aresetn        <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= tgr_pkg::REG_FOREGROUND;
        cfg_wr_data    <= '0;
        s_valid        <= 1'b0;
        s_start_string <= 1'b0;
        s_start_x      <= '0;
        s_start_y      <= '0;
        s_char_code    <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed text with the reset colors: range ends, unprintable bytes, bit 7 glyphs.
        send_char(1'b1, 11'd0, 10'd0, 8'd65);
        send_char(1'b0, 11'd0, 10'd0, 8'd32);
        send_char(1'b0, 11'd0, 10'd0, 8'd126);
        send_char(1'b0, 11'd0, 10'd0, 8'd103);
        send_char(1'b0, 11'd0, 10'd0, 8'd112);
        send_char(1'b0, 11'd0, 10'd0, 8'd0);
        send_char(1'b0, 11'd0, 10'd0, 8'd31);
        send_char(1'b0, 11'd0, 10'd0, 8'd127);
        send_char(1'b0, 11'd0, 10'd0, 8'd255);
        send_char(1'b0, 11'd0, 10'd0, 8'd33);
        // Start fields are ignored without the start flag.
        send_char(1'b0, 11'd2047, 10'd1023, 8'd66);
        // Last glyph that fits the right edge, then the string is dropped.
        send_char(1'b1, 11'd794, 10'd100, 8'd35);
        send_char(1'b0, 11'd0, 10'd0, 8'd88);
        send_char(1'b0, 11'd0, 10'd0, 8'd0);
        send_char(1'b1, 11'd795, 10'd10, 8'd97);
        send_char(1'b1, 11'd2047, 10'd1023, 8'd90);
        send_char(1'b1, 11'd1024, 10'd0, 8'd81);
        // Bottom clipping: partial, single row, and fully clipped glyphs.
        send_char(1'b1, 11'd0, 10'd596, 8'd72);
        send_char(1'b1, 11'd6, 10'd599, 8'd77);
        send_char(1'b1, 11'd12, 10'd600, 8'd87);
        send_char(1'b1, 11'd18, 10'd1023, 8'd64);
        send_char(1'b0, 11'd0, 10'd0, 8'd65);
        send_char(1'b1, 11'd789, 10'd593, 8'd56);
        send_char(1'b0, 11'd0, 10'd0, 8'd57);

        // Random strings under several color settings, one phase without any idling.
        wait_idle();
        load_colors(32'h0000_0000, 32'hFFFF_FFFF);
        run_random_phase();

        wait_idle();
        load_colors($urandom, $urandom);
        no_idle = 1'b1;
        run_random_phase();
        no_idle = 1'b0;

        wait_idle();
        load_colors(32'hFFFF_FFFF, 32'h0000_0000);
        run_random_phase();

        wait_idle();
        load_colors($urandom, $urandom);
        run_random_phase();

        s_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.pending_pixels.size() != 0) begin
            $error("%0d expected pixel words never arrived", sb.pending_pixels.size());
            sb.errors++;
        end

        $display("Covered %0d characters and %0d pixel words across %0d color settings.",
                 sb.chars_accepted, sb.pixels_checked, color_settings + 1);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
